// ===== rtl/core/dlprs_pkg.sv =====
// Shared constants and types for the dual length-prefixed record stack.
package dlprs_pkg;

   // Size of the shared byte store; a power of two from 1024 to 65536.
   localparam int unsigned MEM_BYTES = 65536;
   localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned RSP_USER_W = 3;
   localparam int unsigned CSR_AW     = 3;
   localparam int unsigned CSR_DW     = 32;

   localparam logic [1:0] CMD_PUSH_OPEN = 2'd0;
   localparam logic [1:0] CMD_PUSH_BYTE = 2'd1;
   localparam logic [1:0] CMD_POP_OPEN  = 2'd2;
   localparam logic [1:0] CMD_POP_BYTE  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_REFUSED = 3'd1;
   localparam logic [2:0] ST_UNDER   = 3'd2;
   localparam logic [2:0] ST_SMALL   = 3'd3;
   localparam logic [2:0] ST_SEQ     = 3'd4;

   // Register select bit (paddr[2]) of the configuration port.
   localparam logic CSR_DS_TOP = 1'b0;
   localparam logic CSR_RS_TOP = 1'b1;

   localparam logic [15:0] DS_TOP_RESET = 16'h8000;
   localparam logic [15:0] RS_TOP_RESET = 16'hF000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PUSH,
      PH_POP
   } phase_type;

endpackage

// ===== rtl/core/dlprs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module dlprs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dual_length_prefixed_record_stack.sv =====
// Top level of the dual length-prefixed record stack.
//
// Two stacks of variable-length records grow downward in one byte RAM. The
// data stack empties at ds_top and the return stack at rs_top; both are set
// through the APB-style csr_ port, and writing either also resets its stack
// pointer. Each record starts with a 16-bit little-endian length prefix.
// Commands arrive as beats on the req_ stream; every beat gives exactly one
// result beat on the rsp_ stream, held in an output register.
// Beat handling, set by the single RAM write port and its registered read:
//   push_byte, refused, underflow and sequence-error beats: S_IDLE only
//   push_open (two prefix bytes written): S_IDLE, then S_WR_HI
//   pop_byte (one RAM read): S_IDLE, then S_RD_BYTE
//   pop_open (two prefix bytes read): S_IDLE, S_RD_LO, then S_RD_HI
// A push_open result appears in the cycle after acceptance, while the high
// prefix byte is written; every other result is registered in the last state
// of its beat. A new beat is taken while the block is idle and the output
// register is empty or being emptied, so a stalled receiver holds the block
// after at most one waiting result.
// Reset sets pointers and tops to their reset values and clears sequencing
// state; the RAM content is left as is and needs no clearing pass.
module dual_length_prefixed_record_stack (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // length [15:0], max_len [31:16], data_byte [39:32]
   input  logic [dlprs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd [1:0], stack_sel [2]
   input  logic [dlprs_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // record_len [15:0], out_byte [23:16]
   output logic [dlprs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [2:0]
   output logic [dlprs_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dlprs_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [dlprs_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [dlprs_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                 csr_pready
);

   import dlprs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_HI,
      S_RD_LO,
      S_RD_HI,
      S_RD_BYTE
   } state_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] ds_top_ff, ds_top_in;
   logic [15:0] rs_top_ff, rs_top_in;
   logic [15:0] ds_ptr_ff, ds_ptr_in;
   logic [15:0] rs_ptr_ff, rs_ptr_in;
   logic [15:0] cursor_ff, cursor_in;
   logic [15:0] left_ff, left_in;
   logic        active_ff, active_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] maxlen_ff, maxlen_in;
   logic        psel_ff, psel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        last_ff, last_in;

   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [MEM_AW-1:0] mem_raddr;
   logic [7:0]        mem_rdata;

   logic [1:0]  req_cmd;
   logic        req_sel;
   logic [15:0] req_length;
   logic [15:0] req_max_len;
   logic [7:0]  req_byte;
   logic        accept;
   logic        csr_wr;
   logic [15:0] cur_ptr;
   logic [15:0] cur_top;
   logic [16:0] need;
   logic        refuse;
   logic [15:0] new_ptr;
   logic [15:0] size;
   logic [15:0] pop_ptr;

   dlprs_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_cmd     = req_tuser[1:0];
   assign req_sel     = req_tuser[2];
   assign req_length  = req_tdata[15:0];
   assign req_max_len = req_tdata[31:16];
   assign req_byte    = req_tdata[39:32];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         CSR_DS_TOP: csr_prdata = {16'd0, ds_top_ff};
         CSR_RS_TOP: csr_prdata = {16'd0, rs_top_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cur_ptr = req_sel ? rs_ptr_ff : ds_ptr_ff;
   assign cur_top = req_sel ? rs_top_ff : ds_top_ff;
   assign need    = {1'b0, req_length} + 17'd2;
   assign refuse  = (req_length == 16'd0) || ({1'b0, cur_ptr} < need) ||
                    (req_sel && (rs_ptr_ff < ds_top_ff));
   assign new_ptr = cur_ptr - need[15:0];
   assign size    = {mem_rdata, hold_ff};
   assign pop_ptr = addr_ff + size + 16'd2;

   // Reads and writes of the RAM never fall in the same cycle, and a read is
   // always issued after any write it depends on has landed, so no forwarding
   // is needed.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ds_top_in    = ds_top_ff;
      rs_top_in    = rs_top_ff;
      ds_ptr_in    = ds_ptr_ff;
      rs_ptr_in    = rs_ptr_ff;
      cursor_in    = cursor_ff;
      left_in      = left_ff;
      active_in    = active_ff;
      addr_in      = addr_ff;
      hold_in      = hold_ff;
      maxlen_in    = maxlen_ff;
      psel_in      = psel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      rlen_in      = rlen_ff;
      obyte_in     = obyte_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      mem_waddr    = cursor_ff[MEM_AW-1:0];
      mem_wdata    = req_byte;
      mem_raddr    = cursor_ff[MEM_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_SEQ;
               rlen_in      = 16'd0;
               obyte_in     = 8'd0;
               last_in      = 1'b0;
               case (req_cmd)
                  CMD_PUSH_OPEN: begin
                     if (phase_ff == PH_IDLE) begin
                        if (refuse) begin
                           status_in = ST_REFUSED;
                        end else begin
                           status_in = ST_OK;
                           if (req_sel) begin
                              rs_ptr_in = new_ptr;
                           end else begin
                              ds_ptr_in = new_ptr;
                           end
                           mem_we    = 1'b1;
                           mem_waddr = new_ptr[MEM_AW-1:0];
                           mem_wdata = req_length[7:0];
                           hold_in   = req_length[15:8];
                           addr_in   = new_ptr + 16'd1;
                           cursor_in = new_ptr + 16'd2;
                           left_in   = req_length;
                           active_in = req_sel;
                           phase_in  = PH_PUSH;
                           state_in  = S_WR_HI;
                        end
                     end
                  end
                  CMD_PUSH_BYTE: begin
                     if (phase_ff == PH_PUSH) begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        cursor_in = cursor_ff + 16'd1;
                        left_in   = left_ff - 16'd1;
                        if (left_ff == 16'd1) begin
                           last_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     end
                  end
                  CMD_POP_OPEN: begin
                     if (phase_ff == PH_IDLE) begin
                        if (cur_ptr >= cur_top) begin
                           status_in = ST_UNDER;
                        end else begin
                           // The result is produced once both prefix bytes are in.
                           rsp_valid_in = 1'b0;
                           mem_raddr    = cur_ptr[MEM_AW-1:0];
                           addr_in      = cur_ptr;
                           psel_in      = req_sel;
                           maxlen_in    = req_max_len;
                           state_in     = S_RD_LO;
                        end
                     end
                  end
                  CMD_POP_BYTE: begin
                     if (phase_ff == PH_POP) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_RD_BYTE;
                     end
                  end
                  default: begin
                     status_in = ST_SEQ;
                  end
               endcase
            end
         end
         S_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff[MEM_AW-1:0];
            mem_wdata = hold_ff;
            state_in  = S_IDLE;
         end
         S_RD_LO: begin
            hold_in   = mem_rdata;
            mem_raddr = addr_ff[MEM_AW-1:0] + MEM_AW'(1);
            state_in  = S_RD_HI;
         end
         S_RD_HI: begin
            rsp_valid_in = 1'b1;
            rlen_in      = size;
            obyte_in     = 8'd0;
            last_in      = 1'b0;
            if (size > maxlen_ff) begin
               status_in = ST_SMALL;
            end else begin
               status_in = ST_OK;
               if (psel_ff) begin
                  rs_ptr_in = pop_ptr;
               end else begin
                  ds_ptr_in = pop_ptr;
               end
               active_in = psel_ff;
               if (size == 16'd0) begin
                  last_in = 1'b1;
               end else begin
                  cursor_in = addr_ff + 16'd2;
                  left_in   = size;
                  phase_in  = PH_POP;
               end
            end
            state_in = S_IDLE;
         end
         S_RD_BYTE: begin
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            rlen_in      = 16'd0;
            obyte_in     = mem_rdata;
            last_in      = 1'b0;
            cursor_in    = cursor_ff + 16'd1;
            left_in      = left_ff - 16'd1;
            if (left_ff == 16'd1) begin
               last_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_DS_TOP: begin
               ds_top_in = csr_pwdata[15:0];
               ds_ptr_in = csr_pwdata[15:0];
            end
            CSR_RS_TOP: begin
               rs_top_in = csr_pwdata[15:0];
               rs_ptr_in = csr_pwdata[15:0];
            end
            default: begin
               ds_top_in = ds_top_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         ds_top_ff    <= DS_TOP_RESET;
         rs_top_ff    <= RS_TOP_RESET;
         ds_ptr_ff    <= DS_TOP_RESET;
         rs_ptr_ff    <= RS_TOP_RESET;
         cursor_ff    <= 16'd0;
         left_ff      <= 16'd0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ds_top_ff    <= ds_top_in;
         rs_top_ff    <= rs_top_in;
         ds_ptr_ff    <= ds_ptr_in;
         rs_ptr_ff    <= rs_ptr_in;
         cursor_ff    <= cursor_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff   <= addr_in;
      hold_ff   <= hold_in;
      maxlen_ff <= maxlen_in;
      psel_ff   <= psel_in;
      status_ff <= status_in;
      rlen_ff   <= rlen_in;
      obyte_ff  <= obyte_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {obyte_ff, rlen_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule
